>>> rtl/pgn_pkg.sv
// Package for the gradient noise block: value type, register indexes, permutation ROM,
// fixed-point multiply, gradient dot products and the interpolation step.
// No dependencies.
package pgn_pkg;

   // signed Q16 working value, wide enough for every intermediate
   typedef logic signed [23:0] val_type;
   typedef logic signed [47:0] prod_type;

   // configuration register indexes
   typedef enum logic {CSR_MODE = 1'b0, CSR_FREQ = 1'b1} csr_reg_type;

   localparam int      PERM_SIZE = 256;
   localparam val_type ONE_Q16   = 24'sd65536;
   localparam val_type SQRT2_Q16 = 24'sd92682;
   localparam val_type FADE_C15  = 24'sd983040;
   localparam val_type FADE_C10  = 24'sd655360;

   localparam logic [7:0] PERM_ROM [0:PERM_SIZE-1] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   // hash one lattice index through the permutation, wrapping past 255
   function automatic logic [7:0] perm_at(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] idx;
      idx = a + b;
      return PERM_ROM[idx];
   endfunction

   // Q16 product rounded to nearest, ties toward plus infinity
   function automatic val_type mul_q16(input val_type a, input val_type b);
      prod_type p;
      p = prod_type'(a) * prod_type'(b) + 48'sd32768;
      return val_type'(p >>> 16);
   endfunction

   function automatic val_type lerp_q16(input val_type a, input val_type b,
                                        input val_type s);
      return a + mul_q16(b - a, s);
   endfunction

   // 2D gradient dot, sqrt2 output scale folded into the axis gradients
   function automatic val_type grad2_dot(input logic [2:0] h, input val_type dx,
                                         input val_type dy);
      val_type r;
      unique case (h)
         3'd0:    r = mul_q16(SQRT2_Q16, dx);
         3'd1:    r = mul_q16(-SQRT2_Q16, dx);
         3'd2:    r = mul_q16(SQRT2_Q16, dy);
         3'd3:    r = mul_q16(-SQRT2_Q16, dy);
         3'd4:    r = dx + dy;
         3'd5:    r = dy - dx;
         3'd6:    r = dx - dy;
         default: r = -dx - dy;
      endcase
      return r;
   endfunction

   // 3D gradient dot, components in {-1,0,1} so the sum is exact
   function automatic val_type grad3_dot(input logic [3:0] h, input val_type dx,
                                         input val_type dy, input val_type dz);
      val_type r;
      unique case (h)
         4'd0:    r = dx + dy;
         4'd1:    r = dy - dx;
         4'd2:    r = dx - dy;
         4'd3:    r = -dx - dy;
         4'd4:    r = dx + dz;
         4'd5:    r = dz - dx;
         4'd6:    r = dx - dz;
         4'd7:    r = -dx - dz;
         4'd8:    r = dy + dz;
         4'd9:    r = dz - dy;
         4'd10:   r = dy - dz;
         4'd11:   r = -dy - dz;
         4'd12:   r = dx + dy;
         4'd13:   r = dy - dx;
         4'd14:   r = dz - dy;
         default: r = -dy - dz;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/perlin_gradient_noise.sv
// Gradient noise pipeline: scale, split, hash, fade, dot, blend, output.
// Depends on pgn_pkg for the permutation ROM and fixed-point helpers.
//
// Usage: drive req_coord_x/y/z (signed Q16.16) with start high for one
// cycle; a request is taken at every clock edge where start is high and busy
// is low. busy stays low, so a new request may enter every cycle.
// Each request yields exactly one result: rsp_valid pulses for one cycle with
// rsp_noise_value (signed Q2.14, saturated) at the end of the pipeline.
// Results leave in request order. The receiver cannot hold results off.
// Throughput is one request per cycle; the ten register stages are the scale,
// the split, four fade multiplies, three interpolation blends and the output.
// Configuration: csr_index 0 is three_dimensional (bit 0), csr_index 1 is the
// Q8.16 frequency; write only while no request is in flight. Zero frequency
// gives a zero result.
// Reset (synchronous, active high) empties the pipeline and sets 3D mode and
// a frequency of 1.0.
module perlin_gradient_noise
   import pgn_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   input  logic signed [31:0]  req_coord_z,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_noise_value,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [23:0]         csr_write_data
);

   localparam int FRAC_DROP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int LAT       = 10;

   // configuration registers
   logic        mode_ff;
   logic [23:0] freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         freq_ff <= 24'd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE: mode_ff <= csr_write_data[0];
            default:  freq_ff <= csr_write_data;
         endcase
      end
   end

   assign busy = 1'b0;

   // valid and per-request flags travel along the stages
   logic [LAT:1] vld_ff;
   logic [LAT:1] md_ff;
   logic [LAT:1] zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-1:1], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      md_ff   <= {md_ff[LAT-1:1], mode_ff};
      zero_ff <= {zero_ff[LAT-1:1], freq_ff == 24'd0};
   end

   // stage 1: scale coordinates by frequency
   logic signed [55:0] prod_ff [3];
   logic signed [55:0] prod_in [3];

   always_comb begin
      prod_in[0] = 56'(req_coord_x) * 56'(signed'({1'b0, freq_ff}));
      prod_in[1] = 56'(req_coord_y) * 56'(signed'({1'b0, freq_ff}));
      prod_in[2] = 56'(req_coord_z) * 56'(signed'({1'b0, freq_ff}));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // stage 2: split into cell and fraction, hash the x corners
   logic [7:0] cell_ff [3];
   logic [7:0] cell_in [3];
   val_type    t2_ff [3];
   val_type    t2_in [3];
   logic [7:0] hx_ff [2];
   logic [7:0] hx_in [2];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cell_in[a] = prod_ff[a][39:32];
         t2_in[a]   = val_type'({8'd0, (prod_ff[a][31:16] >> FRAC_DROP) << FRAC_DROP});
      end
      hx_in[0] = perm_at(cell_ff[0] ^ cell_ff[0], cell_in[0]);
      hx_in[1] = perm_at(cell_in[0], 8'd1);
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      t2_ff   <= t2_in;
      hx_ff   <= hx_in;
   end

   // stage 3: hash the xy corners, first fade step
   logic [7:0] hxy_ff [4];
   logic [7:0] hxy_in [4];
   logic [7:0] iz3_ff;
   val_type    t3_ff [3];
   val_type    m1_ff [3];
   val_type    m1_in [3];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         hxy_in[c] = perm_at(hx_ff[c % 2], cell_ff[1] + 8'(c / 2));
      end
      for (int a = 0; a < 3; a++) begin
         m1_in[a] = mul_q16((t2_ff[a] <<< 2) + (t2_ff[a] <<< 1) - FADE_C15, t2_ff[a])
                    + FADE_C10;
      end
   end

   always_ff @(posedge clock) begin
      hxy_ff <= hxy_in;
      iz3_ff <= cell_ff[2];
      t3_ff  <= t2_ff;
      m1_ff  <= m1_in;
   end

   // stage 4: hash all corners (3D) or keep the xy hashes (2D), second fade step
   logic [7:0] hc_ff [8];
   logic [7:0] hc_in [8];
   val_type    t4_ff [3];
   val_type    m2_ff [3];
   val_type    m2_in [3];

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         hc_in[c] = md_ff[3] ? perm_at(hxy_ff[c % 4], iz3_ff + 8'(c / 4)) : hxy_ff[c % 4];
      end
      for (int a = 0; a < 3; a++) begin
         m2_in[a] = mul_q16(m1_ff[a], t3_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      hc_ff <= hc_in;
      t4_ff <= t3_ff;
      m2_ff <= m2_in;
   end

   // stage 5: corner dot products, third fade step
   val_type dot5_ff [8];
   val_type dot5_in [8];
   val_type t5_ff [3];
   val_type m3_ff [3];
   val_type m3_in [3];

   always_comb begin
      val_type dx, dy, dz;
      for (int c = 0; c < 8; c++) begin
         dx = c[0] ? t4_ff[0] - ONE_Q16 : t4_ff[0];
         dy = c[1] ? t4_ff[1] - ONE_Q16 : t4_ff[1];
         dz = c[2] ? t4_ff[2] - ONE_Q16 : t4_ff[2];
         dot5_in[c] = md_ff[4] ? grad3_dot(hc_ff[c][3:0], dx, dy, dz)
                               : grad2_dot(hc_ff[c][2:0], dx, dy);
      end
      for (int a = 0; a < 3; a++) begin
         m3_in[a] = mul_q16(m2_ff[a], t4_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      dot5_ff <= dot5_in;
      t5_ff   <= t4_ff;
      m3_ff   <= m3_in;
   end

   // stage 6: last fade step, hold the dots
   val_type dot6_ff [8];
   val_type fade_ff [3];
   val_type fade_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         fade_in[a] = mul_q16(m3_ff[a], t5_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      dot6_ff <= dot5_ff;
      fade_ff <= fade_in;
   end

   // stage 7: blend along x
   val_type lx_ff [4];
   val_type lx_in [4];
   val_type sy7_ff;
   val_type sz7_ff;

   always_comb begin
      for (int p = 0; p < 4; p++) begin
         lx_in[p] = lerp_q16(dot6_ff[2*p], dot6_ff[2*p+1], fade_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      lx_ff  <= lx_in;
      sy7_ff <= fade_ff[1];
      sz7_ff <= fade_ff[2];
   end

   // stage 8: blend along y
   val_type ly_ff [2];
   val_type ly_in [2];
   val_type sz8_ff;

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         ly_in[p] = lerp_q16(lx_ff[2*p], lx_ff[2*p+1], sy7_ff);
      end
   end

   always_ff @(posedge clock) begin
      ly_ff  <= ly_in;
      sz8_ff <= sz7_ff;
   end

   // stage 9: blend along z in 3D, pass the near plane in 2D
   val_type lz_ff;
   val_type lz_in;

   always_comb begin
      lz_in = md_ff[8] ? lerp_q16(ly_ff[0], ly_ff[1], sz8_ff) : ly_ff[0];
   end

   always_ff @(posedge clock) begin
      lz_ff <= lz_in;
   end

   // stage 10: round to Q2.14, saturate, force zero for zero frequency
   logic signed [15:0] out_in;
   logic signed [24:0] q_sum;

   always_comb begin
      q_sum = (25'(lz_ff) + 25'sd2) >>> 2;
      if (zero_ff[9]) begin
         out_in = '0;
      end else if (q_sum > 25'sd32767) begin
         out_in = 16'sh7fff;
      end else if (q_sum < -25'sd32768) begin
         out_in = -16'sh8000;
      end else begin
         out_in = q_sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_noise_value <= out_in;
   end

   assign rsp_valid = vld_ff[LAT];

   // every request comes out at the end of the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("request lost in pipeline");

   // zero frequency gives a zero result
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[9] && zero_ff[9]) |=> (rsp_noise_value == 16'sd0))
      else $error("zero frequency gave nonzero result");

   // nothing leaves right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule

>>> verif/tb.sv
// Testbench for perlin_gradient_noise: directed and random requests checked
// against a fixed-point gradient noise predictor. Depends on pgn_pkg.
`timescale 1ns / 100ps

module tb
   import pgn_pkg::*;
;

   localparam int CLK_HALF  = 4;
   localparam int PIPE_LAT  = 10;
   localparam int IDLE_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_noise_value;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = 1'b0;
   logic [23:0]        csr_write_data = '0;

   // predictor copy of the registers
   logic        mode_3d;
   logic [23:0] freq_q8_16;

   logic signed [15:0] noise_expected [$];
   int errors, requests_sent, results_seen, idle_cycles;
   bit no_gaps;

   perlin_gradient_noise dut (.*);

   always #CLK_HALF clock = ~clock;

   // ---------------- noise predictor ----------------
   function automatic longint q16_mul(longint a, longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   function automatic longint quintic_fade(longint t);
      longint h;
      h = 6 * t - 15 * 65536;
      h = q16_mul(h, t) + 10 * 65536;
      h = q16_mul(h, t);
      h = q16_mul(h, t);
      return q16_mul(h, t);
   endfunction

   function automatic longint blend(longint a, longint b, longint s);
      return a + q16_mul(b - a, s);
   endfunction

   // scale a coordinate and split into lattice index and Q0.16 fraction
   function automatic void split_point(logic signed [31:0] c, output logic [7:0] lat_idx,
                                       output longint frac);
      longint prod;
      logic [63:0] biased;
      prod = longint'(c) * longint'({1'b0, freq_q8_16});
      biased = 64'(prod) + (64'd1 << 55);
      lat_idx = biased[39:32];
      frac = longint'({1'b0, biased[31:16]});
   endfunction

   function automatic longint corner_dot2(logic [7:0] h, longint dx, longint dy);
      longint gx, gy;
      case (h[2:0])
         3'd0: begin gx = 92682;  gy = 0; end
         3'd1: begin gx = -92682; gy = 0; end
         3'd2: begin gx = 0;      gy = 92682; end
         3'd3: begin gx = 0;      gy = -92682; end
         3'd4: begin gx = 65536;  gy = 65536; end
         3'd5: begin gx = -65536; gy = 65536; end
         3'd6: begin gx = 65536;  gy = -65536; end
         default: begin gx = -65536; gy = -65536; end
      endcase
      return (gx * dx + gy * dy + 32768) >>> 16;
   endfunction

   function automatic longint corner_dot3(logic [7:0] h, longint dx, longint dy,
                                          longint dz);
      case (h[3:0])
         4'd0, 4'd12: return dx + dy;
         4'd1, 4'd13: return dy - dx;
         4'd2:        return dx - dy;
         4'd3:        return -dx - dy;
         4'd4:        return dx + dz;
         4'd5:        return dz - dx;
         4'd6:        return dx - dz;
         4'd7:        return -dx - dz;
         4'd8:        return dy + dz;
         4'd9, 4'd14: return dz - dy;
         4'd10:       return dy - dz;
         default:     return -dy - dz;
      endcase
   endfunction

   function automatic logic [7:0] lattice_hash(logic [7:0] a, logic [7:0] b);
      logic [7:0] idx;
      idx = a + b;
      return PERM_ROM[idx];
   endfunction

   function automatic logic signed [15:0] noise_at(logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
      logic [7:0] ix, iy, iz, h0, h1, h00, h10, h01, h11;
      longint tx, ty, tz, sx, sy, sz, v, q, near_v, far_v;
      if (freq_q8_16 == 0) return '0;
      split_point(x, ix, tx);
      split_point(y, iy, ty);
      split_point(z, iz, tz);
      h0 = PERM_ROM[ix];
      h1 = PERM_ROM[ix + 8'd1];
      h00 = lattice_hash(h0, iy);
      h10 = lattice_hash(h1, iy);
      h01 = lattice_hash(h0, iy + 8'd1);
      h11 = lattice_hash(h1, iy + 8'd1);
      sx = quintic_fade(tx);
      sy = quintic_fade(ty);
      sz = quintic_fade(tz);
      if (!mode_3d) begin
         v = blend(blend(corner_dot2(h00, tx, ty), corner_dot2(h10, tx - 65536, ty), sx),
                   blend(corner_dot2(h01, tx, ty - 65536),
                         corner_dot2(h11, tx - 65536, ty - 65536), sx), sy);
      end else begin
         near_v = blend(
            blend(corner_dot3(lattice_hash(h00, iz), tx, ty, tz),
                  corner_dot3(lattice_hash(h10, iz), tx - 65536, ty, tz), sx),
            blend(corner_dot3(lattice_hash(h01, iz), tx, ty - 65536, tz),
                  corner_dot3(lattice_hash(h11, iz), tx - 65536, ty - 65536, tz), sx),
            sy);
         far_v = blend(
            blend(corner_dot3(lattice_hash(h00, iz + 8'd1), tx, ty, tz - 65536),
                  corner_dot3(lattice_hash(h10, iz + 8'd1), tx - 65536, ty,
                              tz - 65536), sx),
            blend(corner_dot3(lattice_hash(h01, iz + 8'd1), tx, ty - 65536,
                              tz - 65536),
                  corner_dot3(lattice_hash(h11, iz + 8'd1), tx - 65536, ty - 65536,
                              tz - 65536), sx),
            sy);
         v = blend(near_v, far_v, sz);
      end
      q = (v + 2) >>> 2;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return 16'(q);
   endfunction

   // ---------------- drivers ----------------
   task automatic csr_write(csr_reg_type idx, logic [23:0] data);
      @(negedge clock);
      start <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MODE) mode_3d = data[0];
      else freq_q8_16 = data;
   endtask

   // hold start low for a random stretch, mostly short
   task automatic idle_gap();
      int n, r;
      if (no_gaps) return;
      r = $urandom_range(99);
      n = (r < 65) ? 0 : (r < 93) ? $urandom_range(3, 1) : $urandom_range(40, 8);
      if (n == 0) return;
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      logic was_busy;
      @(negedge clock);
      start <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do begin
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      noise_expected.push_back(noise_at(x, y, z));
      requests_sent++;
      idle_gap();
   endtask

   // let the pipeline drain before touching the registers
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (noise_expected.size() > 0) @(negedge clock);
      repeat (PIPE_LAT + 2) @(negedge clock);
   endtask

   task automatic report_mismatch(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // ---------------- result checker and watchdog ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (noise_expected.size() == 0)
            report_mismatch($sformatf("unexpected result %0d", rsp_noise_value));
         else begin
            if (rsp_noise_value !== noise_expected[0])
               report_mismatch($sformatf("noise_value got %0d want %0d",
                                         rsp_noise_value, noise_expected[0]));
            void'(noise_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_write_enable) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d idle cycles", idle_cycles);
         $display("perlin_gradient_noise verification failed");
         $finish;
      end
   end

   // ---------------- tests ----------------
   function automatic logic signed [31:0] rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom;                                   // anywhere
      if (r < 85) return $signed($urandom_range(16 << 16, 0)) - (8 << 16); // near origin
      return $signed(32'($urandom_range(3, 0)) << 30) ^ $urandom_range(255);
   endfunction

   task automatic test_directed();
      logic signed [31:0] ext [4];
      ext = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1};
      foreach (ext[i]) send_point(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
      send_point(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);   // cell centre
      send_point(32'sh00FF_FFFF, -32'sh0100_0000, 32'sh0100_0000);  // cell wrap
      drain();
      csr_write(CSR_MODE, 24'd0);
      foreach (ext[i]) send_point(ext[i], ext[(i + 3) % 4], ext[i]);
      send_point(32'sh0000_4000, 32'sh0000_C000, 32'sh7FFF_FFFF);
      drain();
      // zero frequency forces zero
      csr_write(CSR_FREQ, 24'd0);
      send_point(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_8000);
      drain();
      csr_write(CSR_MODE, 24'd1);
      send_point(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_8000);
      drain();
      // largest scale
      csr_write(CSR_FREQ, 24'hFF_FFFF);
      foreach (ext[i]) send_point(ext[i], ext[(i + 1) % 4], ext[(i + 3) % 4]);
      drain();
   endtask

   task automatic test_random(logic three_d, logic [23:0] freq, int count);
      csr_write(CSR_MODE, {23'd0, three_d});
      csr_write(CSR_FREQ, freq);
      repeat (count) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
   endtask

   initial begin
      mode_3d = 1'b1;
      freq_q8_16 = 24'd65536;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1'b1, 24'd65536, 120);
      test_random(1'b0, 24'd65536, 120);
      no_gaps = 1'b1;
      test_random(1'b1, 24'($urandom), 80);
      test_random(1'b0, 24'($urandom), 80);
      no_gaps = 1'b0;
      test_random(1'b1, 24'd1, 50);
      test_random(1'b0, 24'hFF_FFFF, 50);
      test_random(1'b1, 24'($urandom_range(4 << 16, 1)), 100);
      test_random(1'b0, 24'($urandom_range(4 << 16, 1)), 100);
      repeat (PIPE_LAT + 5) @(negedge clock);
      $display("Covered %0d requests, %0d results, 2D and 3D modes, frequencies 0 to max.",
               requests_sent, results_seen);
      if (errors == 0 && noise_expected.size() == 0)
         $display("perlin_gradient_noise verification clean");
      else
         $display("perlin_gradient_noise verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/pgn_pkg.sv
rtl/perlin_gradient_noise.sv
verif/tb.sv
